/* rtl/core/homogeneous_point_transform_unit_defines.svh */
// Assertion macros used by the top module of the point transform unit.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_UNIT_DEFINES_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HPT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("point transform check failed");

// Next-cycle implication, checked out of reset.
`define HPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("point transform check failed");

`endif

/* rtl/core/hpt_pkg.sv */
package hpt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int CFG_W         = 64;
  localparam int REG_CNT       = 8;
  localparam int IDX_W         = 3;
  localparam int LANES         = 3;
  localparam int MAT_N         = 4;
  // Quotient bits produced by the divider chain, one per cell.
  localparam int Q_W           = 33;
  localparam int SUM_W         = 66;
  localparam int MAG_W         = 65;
  localparam int REM_W         = 66;

  localparam logic [COORD_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] NEG_MAX = 32'h8000_0000;

  localparam logic [CFG_W-1:0] CFG_RESET [REG_CNT] = '{
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
  };

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   lo;
    logic [Q_W-1:0]   q;
    logic             ovf;
    logic             neg;
  } lane_t;

  typedef struct packed {
    logic                   valid;
    logic                   wz;
    logic [MAG_W-1:0]       den;
    lane_t [LANES-1:0]      lane;
  } pipe_t;

endpackage

/* rtl/core/hpt_ifs.sv */
interface hpt_pnt_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  in_x;
  logic signed [31:0]  in_y;
  logic signed [31:0]  in_z;
  modport source (output valid, in_x, in_y, in_z, input ready);
  modport sink (input valid, in_x, in_y, in_z, output ready);
endinterface

interface hpt_res_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  out_x;
  logic signed [31:0]  out_y;
  logic signed [31:0]  out_z;
  logic                w_zero;
  logic                clipped;
  modport source (output valid, out_x, out_y, out_z, w_zero, clipped, input ready);
  modport sink (input valid, out_x, out_y, out_z, w_zero, clipped, output ready);
endinterface

/* rtl/core/hpt_front.sv */
module hpt_front #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [hpt_pkg::COORD_W-1:0]   in_x,
  input  logic signed [hpt_pkg::COORD_W-1:0]   in_y,
  input  logic signed [hpt_pkg::COORD_W-1:0]   in_z,
  input  logic signed [hpt_pkg::COORD_W-1:0]   mat [hpt_pkg::MAT_N][hpt_pkg::MAT_N],
  output hpt_pkg::pipe_t                       dout
);
  import hpt_pkg::*;

  localparam int DIV_W = MAG_W + FRAC_BITS;
  localparam int HI_W  = DIV_W - Q_W;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] t;
    t = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    return t[MAG_W-1:0];
  endfunction

  logic                        v1;
  logic                        v2;
  logic signed [COORD_W-1:0]   pt [LANES];
  logic signed [2*COORD_W-1:0] prod [LANES][MAT_N];
  logic signed [SUM_W-1:0]     sum [MAT_N];
  pipe_t                       nxt;

  assign pt[0] = in_x;
  assign pt[1] = in_y;
  assign pt[2] = in_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // Stage one: twelve exact products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < LANES; r++) begin
        for (int c = 0; c < MAT_N; c++) begin
          prod[r][c] <= pt[r] * mat[r][c];
        end
      end
    end
  end

  // Stage two: column sums, translation row scaled by one.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < MAT_N; c++) begin
        sum[c] <= SUM_W'(prod[0][c]) + SUM_W'(prod[1][c]) + SUM_W'(prod[2][c])
                  + (SUM_W'(mat[3][c]) <<< FRAC_BITS);
      end
    end
  end

  // Stage three: magnitudes, signs and the overflow test of the top quotient part.
  always_comb begin
    logic [DIV_W-1:0] dvd;
    logic [HI_W-1:0]  hi;
    nxt       = '0;
    nxt.valid = v2;
    nxt.wz    = (sum[3] == '0);
    nxt.den   = mag_of(sum[3]);
    for (int l = 0; l < LANES; l++) begin
      dvd = {mag_of(sum[l]), {FRAC_BITS{1'b0}}};
      hi  = dvd[DIV_W-1:Q_W];
      nxt.lane[l].rem = REM_W'(hi);
      nxt.lane[l].lo  = dvd[Q_W-1:0];
      nxt.lane[l].q   = '0;
      nxt.lane[l].ovf = (REM_W'(hi) >= REM_W'(nxt.den));
      nxt.lane[l].neg = sum[l][SUM_W-1] ^ sum[3][SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule

/* rtl/core/hpt_div_cell.sv */
module hpt_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  hpt_pkg::pipe_t din,
  output hpt_pkg::pipe_t dout
);
  import hpt_pkg::*;

  pipe_t nxt;

  // One restoring division step for each of the three lanes against the shared w.
  always_comb begin
    logic [REM_W-1:0] t;
    logic             b;
    nxt = din;
    for (int l = 0; l < LANES; l++) begin
      t = {din.lane[l].rem[REM_W-2:0], din.lane[l].lo[Q_W-1]};
      b = (t >= REM_W'(din.den));
      nxt.lane[l].rem = b ? (t - REM_W'(din.den)) : t;
      nxt.lane[l].lo  = {din.lane[l].lo[Q_W-2:0], 1'b0};
      nxt.lane[l].q   = {din.lane[l].q[Q_W-2:0], b};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule

/* rtl/core/homogeneous_point_transform_unit.sv */
// Homogeneous point transform: each beat carries a point (x, y, z) in signed fixed point,
// which is taken as the row vector (x, y, z, 1), multiplied by the 4x4 matrix held in
// the eight 64-bit configuration registers, and divided by the resulting w to give the
// projected point in the same format. The block takes one point in every cycle unless
// stalled and delivers one result per point, in order, through the multiply, sum and sign
// preparation registers, a chain of 33 divider cells that each settle one quotient bit for
// all three coordinates, and the output register. When w is zero the coordinates are zero
// and w_zero is set; a quotient outside the 32-bit range saturates and sets clipped. The
// whole pipeline stalls only while a result waits untaken at the output. The user must
// write configuration only while the block is idle; the block itself does not enforce it.
`include "homogeneous_point_transform_unit_defines.svh"

module homogeneous_point_transform_unit #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [hpt_pkg::IDX_W-1:0]   cfg_idx,
  input  logic [hpt_pkg::CFG_W-1:0]   cfg_data,
  hpt_pnt_if.sink                     pnt,
  hpt_res_if.source                   res
);
  import hpt_pkg::*;

  logic [CFG_W-1:0]          cfg [REG_CNT];
  logic signed [COORD_W-1:0] mat [MAT_N][MAT_N];
  logic                      en;
  pipe_t                     chain [Q_W+1];

  logic [COORD_W-1:0]        o_crd [LANES];
  logic                      o_wz;
  logic                      o_clip;
  logic                      o_valid;
  logic [COORD_W-1:0]        crd_next [LANES];
  logic                      clip_next;

  // The whole pipe advances unless a finished result is held back by the sink.
  assign en        = !o_valid || res.ready;
  assign pnt.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_CNT; i++) begin
        cfg[i] <= CFG_RESET[i];
      end
    end else if (cfg_we) begin
      cfg[cfg_idx] <= cfg_data;
    end
  end

  // Each register holds two entries of one row, the lower column in the low half.
  always_comb begin
    for (int r = 0; r < MAT_N; r++) begin
      for (int c = 0; c < MAT_N; c++) begin
        mat[r][c] = cfg[r*2 + c/2][(c%2)*COORD_W +: COORD_W];
      end
    end
  end

  hpt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (pnt.valid),
    .in_x     (pnt.in_x),
    .in_y     (pnt.in_y),
    .in_z     (pnt.in_z),
    .mat      (mat),
    .dout     (chain[0])
  );

  for (genvar k = 0; k < Q_W; k++) begin : g_cell
    hpt_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[k]),
      .dout (chain[k+1])
    );
  end

  // Sign, saturation and the zero-w case of the finished quotients. A zero quotient stays zero either way.
  always_comb begin
    logic [Q_W-1:0] q;
    clip_next = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      q = chain[Q_W].lane[l].q;
      crd_next[l] = '0;
      if (chain[Q_W].wz) begin
        crd_next[l] = '0;
      end else if (chain[Q_W].lane[l].neg) begin
        if (chain[Q_W].lane[l].ovf || q > Q_W'(NEG_MAX)) begin
          crd_next[l] = NEG_MAX;
          clip_next   = 1'b1;
        end else begin
          crd_next[l] = COORD_W'(-q[COORD_W-1:0]);
        end
      end else begin
        if (chain[Q_W].lane[l].ovf || q > Q_W'(POS_MAX)) begin
          crd_next[l] = POS_MAX;
          clip_next   = 1'b1;
        end else begin
          crd_next[l] = q[COORD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= chain[Q_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_crd  <= crd_next;
      o_wz   <= chain[Q_W].wz;
      o_clip <= clip_next;
    end
  end

  assign res.valid   = o_valid;
  assign res.out_x   = o_crd[0];
  assign res.out_y   = o_crd[1];
  assign res.out_z   = o_crd[2];
  assign res.w_zero  = o_wz;
  assign res.clipped = o_clip;

  // A zero w gives a zero point and never a saturation.
  `HPT_ASSERT_NOW(a_wz_zero, res.valid && res.w_zero, res.out_x == 0 && res.out_y == 0 && res.out_z == 0 && !res.clipped)
  // A clipped result carries at least one coordinate at a range limit.
  `HPT_ASSERT_NOW(a_clip_lim, res.valid && res.clipped, res.out_x == POS_MAX || res.out_x == NEG_MAX || res.out_y == POS_MAX || res.out_y == NEG_MAX || res.out_z == POS_MAX || res.out_z == NEG_MAX)
  // Input is refused only while a result waits at the output.
  `HPT_ASSERT_NOW(a_stall_src, !pnt.ready, res.valid && !res.ready)
  // A stall freezes the last divider cell so no beat is lost.
  `HPT_ASSERT_NEXT(a_chain_hold, res.valid && !res.ready, chain[Q_W] == $past(chain[Q_W]))

endmodule

/* tb/sv/homogeneous_point_transform_unit_test.sv */
`timescale 1ns / 100ps

module homogeneous_point_transform_unit_test;
  import hpt_pkg::*;

  // Fraction bits of the fixed-point format in use.
  localparam int FRAC = FRAC_BITS_DEF;

  // Matrix settings used by the directed part.
  localparam int MAT_IDENT = 0;
  localparam int MAT_EXTREME = 1;
  localparam int MAT_W_NULL = 2;

  // Kinds of random matrix used by the random part.
  localparam int KIND_NEAR_UNIT = 0;
  localparam int KIND_WIDE = 1;
  localparam int KIND_W_CANCEL = 2;
  localparam int KIND_ALL_ONES = 3;
  localparam int KIND_COUNT = 4;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic        wz;
    logic        clip;
  } proj_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [IDX_W-1:0]     cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  hpt_pnt_if pnt_ch ();
  hpt_res_if res_ch ();

  homogeneous_point_transform_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .pnt      (pnt_ch),
    .res      (res_ch)
  );

  // Our own copy of the eight matrix registers, kept in step with every write.
  logic [CFG_W-1:0] matrix_regs [REG_CNT];
  logic [CFG_W-1:0] matrix_sets [3][REG_CNT];

  // Projected points that are owed by the block, oldest first.
  proj_t owed_points [$];
  int    mismatch_cnt;

  // When clear, neither side inserts idle cycles between beats.
  bit    idle_en;
  // A one-shot request for the receiver to hold off for a long stretch.
  bit    long_hold;

  always #4 clk = ~clk;

  // The run is cut off if it ever hangs.
  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Signed 32-bit matrix entry at (row, col).
  function automatic logic signed [31:0] entry_at(int row, int col);
    logic [CFG_W-1:0] r;
    r = matrix_regs[row * 2 + col / 2];
    return (col % 2) ? r[63:32] : r[31:0];
  endfunction

  // Full transform of one point: exact sums, magnitude division truncated
  // toward zero, then saturation to the 32-bit range.
  function automatic proj_t transform_point(logic signed [31:0] x, logic signed [31:0] y,
                                            logic signed [31:0] z);
    logic signed [127:0] sums [4];
    logic signed [127:0] xs, ys, zs, e0, e1, e2, e3;
    logic [127:0]        mag, den, quo;
    logic [31:0]         coord [3];
    logic                neg;
    proj_t               r;
    xs = x;
    ys = y;
    zs = z;
    for (int c = 0; c < 4; c++) begin
      e0 = entry_at(0, c);
      e1 = entry_at(1, c);
      e2 = entry_at(2, c);
      e3 = entry_at(3, c);
      sums[c] = xs * e0 + ys * e1 + zs * e2 + (e3 <<< FRAC);
    end
    r = '0;
    if (sums[3] == 0) begin
      // A vanishing w gives the flag and a zero point.
      r.wz = 1'b1;
      return r;
    end
    den = sums[3][127] ? -sums[3] : sums[3];
    for (int c = 0; c < 3; c++) begin
      neg = sums[c][127] ^ sums[3][127];
      mag = sums[c][127] ? -sums[c] : sums[c];
      quo = (mag << FRAC) / den;
      if (quo == 0) begin
        coord[c] = '0;
      end else if (neg) begin
        if (quo > 128'h8000_0000) begin
          coord[c] = NEG_MAX;
          r.clip = 1'b1;
        end else begin
          coord[c] = -quo[31:0];
        end
      end else begin
        if (quo > 128'h7FFF_FFFF) begin
          coord[c] = POS_MAX;
          r.clip = 1'b1;
        end else begin
          coord[c] = quo[31:0];
        end
      end
    end
    r.px = coord[0];
    r.py = coord[1];
    r.pz = coord[2];
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
    mismatch_cnt++;
  endtask

  // Waits until every owed point has come back, so the block is idle.
  task automatic drain;
    while (owed_points.size() != 0) @(posedge clk);
  endtask

  // Drains the block, writes all eight registers on consecutive edges and lowers the enable.
  task automatic load_matrix(logic [CFG_W-1:0] vals [REG_CNT]);
    drain();
    for (int i = 0; i < REG_CNT; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_idx <= IDX_W'(i);
      cfg_data <= vals[i];
      matrix_regs[i] = vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offers one point, after a random idle gap if idle cycles are on, and returns
  // at the edge where it was taken. The expectation is queued at that same edge; a
  // typed value stands in for the prediction where the directed table gives one.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            bit typed, proj_t want);
    int gap;
    gap = idle_en ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      pnt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pnt_ch.valid <= 1'b1;
    pnt_ch.in_x <= x;
    pnt_ch.in_y <= y;
    pnt_ch.in_z <= z;
    do @(posedge clk); while (!pnt_ch.ready);
    owed_points.push_back(typed ? want : transform_point(x, y, z));
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h3_FFFF);
      3: return -$urandom_range(0, 32'h3_FFFF);
      default: return $urandom;
    endcase
  endfunction

  // One matrix entry drawn to suit the kind of setting under test.
  function automatic logic [31:0] rand_entry(int kind);
    if (kind == KIND_NEAR_UNIT) begin
      case ($urandom_range(0, 3))
        0: return 32'h0001_0000;
        1: return 32'h0000_0000;
        2: return $urandom_range(0, 32'h2_0000) - 32'h1_0000;
        default: return $urandom_range(0, 32'h400) - 32'h200;
      endcase
    end
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Receiving side: a random stall before each beat, and one long hold-off
  // when asked, long enough for the pipeline to fill and back-pressure.
  initial begin
    int stall;
    proj_t want, got;
    res_ch.ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      stall = idle_en ? $urandom_range(0, 15) : 0;
      if (long_hold) begin
        stall = 300;
        long_hold = 1'b0;
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      got = '{res_ch.out_x, res_ch.out_y, res_ch.out_z, res_ch.w_zero, res_ch.clipped};
      if (owed_points.size() == 0) begin
        report("unexpected beat", got.px, '0);
      end else begin
        want = owed_points.pop_front();
        if (got.px !== want.px) report("out_x", got.px, want.px);
        if (got.py !== want.py) report("out_y", got.py, want.py);
        if (got.pz !== want.pz) report("out_z", got.pz, want.pz);
        if (got.wz !== want.wz) report("w_zero", 32'(got.wz), 32'(want.wz));
        if (got.clip !== want.clip) report("clipped", 32'(got.clip), 32'(want.clip));
      end
    end
  end

  // Directed table: point, matrix setting, and a typed result where it is
  // obvious. Under the identity matrix a point comes back unchanged; with
  // column three all zero every point gives the zero-w flag.
  typedef struct {
    logic [31:0] x, y, z;
    int          mat;
    bit          typed;
    proj_t       want;
  } row_t;

  row_t rows [$];

  task automatic add_row(logic [31:0] x, logic [31:0] y, logic [31:0] z, int mat, bit typed,
                         proj_t want);
    row_t r;
    r = '{x, y, z, mat, typed, want};
    rows.push_back(r);
  endtask

  initial begin
    int cur_mat;
    int kind;
    logic [CFG_W-1:0] vals [REG_CNT];
    logic [31:0] x, y, z;
    clk = 1'b0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    pnt_ch.valid <= 1'b0;
    pnt_ch.in_x <= '0;
    pnt_ch.in_y <= '0;
    pnt_ch.in_z <= '0;
    mismatch_cnt = 0;
    idle_en = 1'b1;
    long_hold = 1'b0;
    for (int i = 0; i < REG_CNT; i++) begin
      matrix_regs[i] = CFG_RESET[i];
      matrix_sets[MAT_IDENT][i] = CFG_RESET[i];
    end

    // Mostly extreme entries, with w held at one so that the quotient
    // runs far outside the range and saturates both ways.
    matrix_sets[MAT_EXTREME] = '{
      {32'h8000_0000, 32'h7FFF_FFFF}, {32'h0000_0000, 32'h8000_0000},
      {32'h7FFF_FFFF, 32'h8000_0000}, {32'h0000_0000, 32'h7FFF_FFFF},
      {32'hFFFF_FFFF, 32'h0000_0001}, {32'h0000_0000, 32'h8000_0000},
      {32'h7FFF_FFFF, 32'h8000_0000}, {32'h0001_0000, 32'h7FFF_FFFF}
    };
    // Column three zero: w vanishes for every point.
    matrix_sets[MAT_W_NULL] = '{
      {32'h0002_0000, 32'h0001_0000}, {32'h0000_0000, 32'h7FFF_FFFF},
      {32'h0001_0000, 32'h8000_0000}, {32'h0000_0000, 32'h0001_0000},
      {32'h0000_0000, 32'hFFFF_0000}, {32'h0000_0000, 32'h0003_0000},
      {32'h7FFF_FFFF, 32'h8000_0000}, {32'h0000_0000, 32'h1234_5678}
    };

    add_row(32'h0, 32'h0, 32'h0, MAT_IDENT, 1, '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0});
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, MAT_IDENT, 1,
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0});
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, MAT_IDENT, 1,
            '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0});
    add_row(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, MAT_IDENT, 1,
            '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 1'b0, 1'b0});
    add_row(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, MAT_IDENT, 1,
            '{32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0});
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, MAT_EXTREME, 0, '0);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, MAT_EXTREME, 0, '0);
    add_row(32'h0, 32'h0, 32'h0, MAT_EXTREME, 0, '0);
    add_row(32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, MAT_EXTREME, 0, '0);
    add_row(32'h0001_0000, 32'h0, 32'h0, MAT_EXTREME, 0, '0);
    add_row(32'h0, 32'h0, 32'h0, MAT_W_NULL, 1, '{32'h0, 32'h0, 32'h0, 1'b1, 1'b0});
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, MAT_W_NULL, 1,
            '{32'h0, 32'h0, 32'h0, 1'b1, 1'b0});
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, MAT_W_NULL, 1,
            '{32'h0, 32'h0, 32'h0, 1'b1, 1'b0});
    add_row(32'h0, 32'h0, 32'h0, MAT_IDENT, 1, '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: the block starts from its reset matrix, and the
    // registers are reloaded whenever the table moves to another setting.
    cur_mat = MAT_IDENT;
    foreach (rows[i]) begin
      if (rows[i].mat != cur_mat) begin
        pnt_ch.valid <= 1'b0;
        load_matrix(matrix_sets[rows[i].mat]);
        cur_mat = rows[i].mat;
      end
      send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].want);
    end

    // Random part: several phases, each with a freshly written matrix. The
    // first phase asks for the long receiver hold-off; some phases run
    // without any idle cycles on either side.
    for (int ph = 0; ph < 10; ph++) begin
      pnt_ch.valid <= 1'b0;
      kind = ph % KIND_COUNT;
      for (int i = 0; i < REG_CNT; i++) begin
        vals[i] = {rand_entry(kind), rand_entry(kind)};
      end
      if (kind == KIND_NEAR_UNIT || kind == KIND_W_CANCEL) begin
        // Keep w close to one so most results stay in range.
        vals[7][63:32] = 32'h0001_0000 + $urandom_range(0, 32'h100);
      end
      if (kind == KIND_W_CANCEL) begin
        // w = x - y, which vanishes whenever the two coordinates agree.
        vals[1][63:32] = 32'h0001_0000;
        vals[3][63:32] = 32'hFFFF_0000;
        vals[5][63:32] = 32'h0000_0000;
        vals[7][63:32] = 32'h0000_0000;
      end
      if (kind == KIND_ALL_ONES) begin
        foreach (vals[i]) vals[i] = '1;
      end
      load_matrix(vals);
      idle_en = (ph % 3) != 2;
      if (ph == 0) long_hold = 1'b1;
      for (int n = 0; n < 95; n++) begin
        x = rand_coord();
        y = rand_coord();
        z = rand_coord();
        if (kind == KIND_W_CANCEL && $urandom_range(0, 2) == 0) y = x;
        send_point(x, y, z, 1'b0, '0);
      end
    end
    pnt_ch.valid <= 1'b0;

    // Let the last results come out, then allow a margin for stray beats.
    drain();
    repeat (60) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/hpt_pkg.sv
rtl/core/hpt_ifs.sv
rtl/core/hpt_front.sv
rtl/core/hpt_div_cell.sv
rtl/core/homogeneous_point_transform_unit.sv
tb/sv/homogeneous_point_transform_unit_test.sv
